FILE: rtl/weighted_failover_worker_selector_macros.svh
// ---------------------------------------------------------------------------
// Weighted failover worker selector assertion macros
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_FAILOVER_WORKER_SELECTOR_MACROS_SVH
`define WEIGHTED_FAILOVER_WORKER_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define WFWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WFWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wfws_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weighted failover worker selector package
// Widths, reset values, codes, shared types and a saturating add of the selector.
// ---------------------------------------------------------------------------
package wfws_pkg;

  localparam int MAX_WORKERS_DEF = 8;

  localparam int CMD_W  = 2;
  localparam int WK_W   = 3;
  localparam int TIME_W = 32;
  localparam int LOAD_W = 32;
  localparam int INC_W  = 16;
  localparam int CNT_W  = 4;
  localparam int MASK_W = 8;
  localparam int WAIT_W = 16;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0]  RST_WORKER_COUNT     = CNT_W'(8);
  localparam logic [WAIT_W-1:0] RST_RECOVER_WAIT     = WAIT_W'(60 * 1);
  localparam logic [WAIT_W-1:0] RST_RECOVERY_PENALTY = WAIT_W'(20 * 256);

  typedef enum logic [CMD_W-1:0] {
    CMD_SELECT  = 2'd0,
    CMD_SUCCESS = 2'd1,
    CMD_FAILURE = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_WORKER_COUNT     = 3'd0,
    REG_STICKY_ENABLE    = 3'd1,
    REG_LOCAL_ONLY       = 3'd2,
    REG_LOCAL_MASK       = 3'd3,
    REG_RECOVER_WAIT     = 3'd4,
    REG_RECOVERY_PENALTY = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL_SCAN,
    ST_SEL_DONE,
    ST_MAX_SCAN,
    ST_MAX_DONE,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]  worker_count;
    logic              sticky_enable;
    logic              local_only;
    logic [MASK_W-1:0] local_mask;
    logic [WAIT_W-1:0] recover_wait;
    logic [WAIT_W-1:0] recovery_penalty;
  } cfg_t;

  typedef struct packed {
    logic            found;
    logic [WK_W-1:0] chosen;
    logic            probe;
    logic            sticky_hit;
  } res_t;

  typedef struct packed {
    logic [INC_W-1:0]  inc;
    logic [LOAD_W-1:0] load;
  } load_ent_t;

  function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                input logic [INC_W-1:0]  b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {{(LOAD_W + 1 - INC_W){1'b0}}, b};
    return s[LOAD_W] ? {LOAD_W{1'b1}} : s[LOAD_W-1:0];
  endfunction

endpackage

FILE: rtl/wfws_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weighted failover worker selector channels
// Request and response valid/ready channels of the selector.
// ---------------------------------------------------------------------------
interface wfws_req_if;
  import wfws_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [WK_W-1:0]   worker;
  logic              route_valid;
  logic [WK_W-1:0]   route;
  logic              retry;
  logic [TIME_W-1:0] now;
  logic [INC_W-1:0]  increment;

  modport source (
    output valid, command, worker, route_valid, route, retry, now, increment,
    input  ready
  );
  modport sink (
    input  valid, command, worker, route_valid, route, retry, now, increment,
    output ready
  );
endinterface

interface wfws_rsp_if;
  import wfws_pkg::*;

  logic            valid;
  logic            ready;
  logic            found;
  logic [WK_W-1:0] chosen;
  logic            probe;
  logic            sticky_hit;

  modport source (
    output valid, found, chosen, probe, sticky_hit,
    input  ready
  );
  modport sink (
    input  valid, found, chosen, probe, sticky_hit,
    output ready
  );
endinterface

FILE: rtl/wfws_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weighted failover worker selector RAM
// Generic one-write one-read synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module wfws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/wfws_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weighted failover worker selector configuration
// APB register file holding the selector settings.
// ---------------------------------------------------------------------------
module wfws_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wfws_pkg::ADDR_W-1:0] paddr,
  input  logic [wfws_pkg::DATA_W-1:0] pwdata,
  output logic [wfws_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output wfws_pkg::cfg_t              cfg_o
);
  import wfws_pkg::*;

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_WORKER_COUNT:     cfg_d.worker_count     = pwdata[CNT_W-1:0];
        REG_STICKY_ENABLE:    cfg_d.sticky_enable    = pwdata[0];
        REG_LOCAL_ONLY:       cfg_d.local_only       = pwdata[0];
        REG_LOCAL_MASK:       cfg_d.local_mask       = pwdata[MASK_W-1:0];
        REG_RECOVER_WAIT:     cfg_d.recover_wait     = pwdata[WAIT_W-1:0];
        REG_RECOVERY_PENALTY: cfg_d.recovery_penalty = pwdata[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WORKER_COUNT:     prdata = DATA_W'(cfg_q.worker_count);
      REG_STICKY_ENABLE:    prdata = DATA_W'(cfg_q.sticky_enable);
      REG_LOCAL_ONLY:       prdata = DATA_W'(cfg_q.local_only);
      REG_LOCAL_MASK:       prdata = DATA_W'(cfg_q.local_mask);
      REG_RECOVER_WAIT:     prdata = DATA_W'(cfg_q.recover_wait);
      REG_RECOVERY_PENALTY: prdata = DATA_W'(cfg_q.recovery_penalty);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.worker_count     <= RST_WORKER_COUNT;
      cfg_q.sticky_enable    <= 1'b0;
      cfg_q.local_only       <= 1'b0;
      cfg_q.local_mask       <= '0;
      cfg_q.recover_wait     <= RST_RECOVER_WAIT;
      cfg_q.recovery_penalty <= RST_RECOVERY_PENALTY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/wfws_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weighted failover worker selector control
// Sequencer that reads, updates and writes back the worker table.
// ---------------------------------------------------------------------------
module wfws_ctrl #(
  parameter int MAX_WORKERS = wfws_pkg::MAX_WORKERS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wfws_pkg::cfg_t                 cfg_i,
  wfws_req_if.sink                       req_i,
  wfws_rsp_if.source                     rsp_o,
  output logic                           ld_we_o,
  output logic [$clog2(MAX_WORKERS)-1:0] ld_waddr_o,
  output wfws_pkg::load_ent_t            ld_wdata_o,
  output logic [$clog2(MAX_WORKERS)-1:0] ld_raddr_o,
  input  wfws_pkg::load_ent_t            ld_rdata_i,
  output logic                           tm_we_o,
  output logic [$clog2(MAX_WORKERS)-1:0] tm_waddr_o,
  output logic [wfws_pkg::TIME_W-1:0]    tm_wdata_o,
  output logic [$clog2(MAX_WORKERS)-1:0] tm_raddr_o,
  input  logic [wfws_pkg::TIME_W-1:0]    tm_rdata_i
);
  import wfws_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WORKERS);
  localparam int NW_RAW = $clog2(MAX_WORKERS + 1);
  localparam int CMP_W  = (NW_RAW > CNT_W) ? NW_RAW : CNT_W;

  function automatic logic is_local(input logic [MASK_W-1:0] mask,
                                    input logic [CMP_W-1:0]  idx);
    return (idx < CMP_W'(MASK_W)) && mask[idx[2:0]];
  endfunction

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        rd_idx_q, rd_idx_d;
  logic                    rd_pass_q, rd_pass_d;
  logic                    issue_q, issue_d;
  logic                    ev_valid_q, ev_valid_d;
  logic [IDX_W-1:0]        ev_idx_q, ev_idx_d;
  logic                    ev_pass_q, ev_pass_d;
  logic [TIME_W-1:0]       now_q, now_d;
  logic [IDX_W-1:0]        wk_q, wk_d;
  logic                    have_q, have_d;
  logic                    stop_q, stop_d;
  logic                    probe_q, probe_d;
  logic [IDX_W-1:0]        pick_q, pick_d;
  logic [LOAD_W-1:0]       acc_q, acc_d;
  logic [LOAD_W-1:0]       ent_load_q, ent_load_d;
  logic [INC_W-1:0]        ent_inc_q, ent_inc_d;
  logic [MAX_WORKERS-1:0]  err_q, err_d;
  logic [MAX_WORKERS-1:0]  rec_q, rec_d;
  logic                    out_valid_q, out_valid_d;
  res_t                    out_res_q, out_res_d;
  res_t                    hold_res_q, hold_res_d;

  logic [CMP_W-1:0]        n_act;
  logic [MASK_W-1:0]       used_mask;
  logic                    local_mode;
  logic                    rd_last;
  logic                    ev_loc;
  logic                    sel_elig;
  logic [TIME_W-1:0]       elapsed;
  logic                    timed_out;
  logic                    out_free;
  logic                    fin_valid;
  res_t                    fin_res;
  logic                    load_out;
  cmd_e                    cmd;
  logic [IDX_W-1:0]        in_wk;
  logic [IDX_W-1:0]        in_route;
  logic                    wk_ok;
  logic                    route_ok;

  assign n_act = (CMP_W'(cfg_i.worker_count) > CMP_W'(MAX_WORKERS)) ?
                 CMP_W'(MAX_WORKERS) : CMP_W'(cfg_i.worker_count);

  always_comb begin
    used_mask = '0;
    for (int j = 0; j < MASK_W; j++) begin
      used_mask[j] = CMP_W'(j) < n_act;
    end
  end

  assign local_mode = |(cfg_i.local_mask & used_mask);
  assign rd_last    = (CMP_W'(rd_idx_q) == (n_act - 1'b1));
  assign ev_loc     = is_local(cfg_i.local_mask, CMP_W'(ev_idx_q));
  assign sel_elig   = !stop_q && ((!ev_pass_q) == ev_loc) &&
                      !(local_mode && !ev_loc && cfg_i.local_only);
  assign elapsed    = now_q - tm_rdata_i;
  assign timed_out  = !elapsed[TIME_W-1] &&
                      (elapsed > TIME_W'(cfg_i.recover_wait));

  assign cmd      = cmd_e'(req_i.command);
  assign in_wk    = IDX_W'(req_i.worker);
  assign in_route = IDX_W'(req_i.route);
  assign wk_ok    = CMP_W'(req_i.worker) < n_act;
  assign route_ok = CMP_W'(req_i.route) < n_act;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign ld_raddr_o = rd_idx_q;
  assign tm_raddr_o = rd_idx_q;

  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    rd_pass_d   = rd_pass_q;
    issue_d     = issue_q;
    ev_valid_d  = 1'b0;
    ev_idx_d    = rd_idx_q;
    ev_pass_d   = rd_pass_q;
    now_d       = now_q;
    wk_d        = wk_q;
    have_d      = have_q;
    stop_d      = stop_q;
    probe_d     = probe_q;
    pick_d      = pick_q;
    acc_d       = acc_q;
    ent_load_d  = ent_load_q;
    ent_inc_d   = ent_inc_q;
    err_d       = err_q;
    rec_d       = rec_q;
    hold_res_d  = hold_res_q;
    out_res_d   = out_res_q;
    ld_we_o     = 1'b0;
    ld_waddr_o  = in_wk;
    ld_wdata_o  = '{inc: req_i.increment, load: LOAD_W'(req_i.increment)};
    tm_we_o     = 1'b0;
    tm_waddr_o  = in_wk;
    tm_wdata_o  = req_i.now;
    fin_valid   = 1'b0;
    fin_res     = '0;
    load_out    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (cmd == CMD_SELECT) begin
            if (cfg_i.sticky_enable && req_i.route_valid && route_ok &&
                !(req_i.retry && err_q[in_route])) begin
              fin_valid          = 1'b1;
              fin_res.found      = 1'b1;
              fin_res.chosen     = req_i.route;
              fin_res.sticky_hit = 1'b1;
            end else if (n_act == '0) begin
              fin_valid = 1'b1;
            end else begin
              now_d     = req_i.now;
              have_d    = 1'b0;
              stop_d    = 1'b0;
              probe_d   = 1'b0;
              pick_d    = '0;
              acc_d     = '0;
              rd_idx_d  = '0;
              rd_pass_d = 1'b0;
              issue_d   = 1'b1;
              state_d   = ST_SEL_SCAN;
            end
          end else if (!wk_ok) begin
            fin_valid = 1'b1;
          end else begin
            unique case (cmd)
              CMD_SUCCESS: begin
                tm_we_o    = 1'b1;
                tm_wdata_o = '0;
                if (rec_q[in_wk]) begin
                  wk_d      = in_wk;
                  acc_d     = '0;
                  rd_idx_d  = '0;
                  rd_pass_d = 1'b0;
                  issue_d   = 1'b1;
                  state_d   = ST_MAX_SCAN;
                end else begin
                  err_d[in_wk]  = 1'b0;
                  rec_d[in_wk]  = 1'b0;
                  fin_valid     = 1'b1;
                  fin_res.found = 1'b1;
                end
              end
              CMD_FAILURE: begin
                err_d[in_wk]  = 1'b1;
                rec_d[in_wk]  = 1'b0;
                tm_we_o       = 1'b1;
                fin_valid     = 1'b1;
                fin_res.found = 1'b1;
              end
              default: begin
                ld_we_o       = 1'b1;
                fin_valid     = 1'b1;
                fin_res.found = 1'b1;
              end
            endcase
          end
        end
      end

      ST_SEL_SCAN, ST_MAX_SCAN: begin
        if (issue_q) begin
          ev_valid_d = 1'b1;
          if (rd_last) begin
            if (state_q == ST_MAX_SCAN || rd_pass_q) begin
              issue_d = 1'b0;
            end else begin
              rd_pass_d = 1'b1;
              rd_idx_d  = '0;
            end
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        if (ev_valid_q) begin
          if (state_q == ST_SEL_SCAN) begin
            if (sel_elig) begin
              if (err_q[ev_idx_q]) begin
                if (!rec_q[ev_idx_q] && timed_out) begin
                  rec_d[ev_idx_q] = 1'b1;
                  tm_we_o         = 1'b1;
                  tm_waddr_o      = ev_idx_q;
                  tm_wdata_o      = now_q;
                  pick_d          = ev_idx_q;
                  have_d          = 1'b1;
                  probe_d         = 1'b1;
                  stop_d          = 1'b1;
                  ent_load_d      = ld_rdata_i.load;
                  ent_inc_d       = ld_rdata_i.inc;
                end
              end else if (!have_q || ld_rdata_i.load < acc_q) begin
                acc_d      = ld_rdata_i.load;
                pick_d     = ev_idx_q;
                have_d     = 1'b1;
                probe_d    = 1'b0;
                ent_load_d = ld_rdata_i.load;
                ent_inc_d  = ld_rdata_i.inc;
                if (ev_loc) begin
                  stop_d = 1'b1;
                end
              end
            end
          end else begin
            if (!err_q[ev_idx_q] && ld_rdata_i.load > acc_q) begin
              acc_d = ld_rdata_i.load;
            end
            if (ev_idx_q == wk_q) begin
              ent_load_d = ld_rdata_i.load;
              ent_inc_d  = ld_rdata_i.inc;
            end
          end
          if (!issue_q) begin
            state_d = (state_q == ST_SEL_SCAN) ? ST_SEL_DONE : ST_MAX_DONE;
          end
        end
      end

      ST_SEL_DONE: begin
        if (have_q && !is_local(cfg_i.local_mask, CMP_W'(pick_q))) begin
          ld_we_o    = 1'b1;
          ld_waddr_o = pick_q;
          ld_wdata_o = '{inc: ent_inc_q, load: sat_add(ent_load_q, ent_inc_q)};
        end
        fin_valid      = 1'b1;
        fin_res.found  = have_q;
        fin_res.chosen = have_q ? WK_W'(pick_q) : '0;
        fin_res.probe  = have_q && probe_q;
        state_d        = ST_IDLE;
      end

      ST_MAX_DONE: begin
        if (ent_load_q != '0) begin
          ld_we_o    = 1'b1;
          ld_waddr_o = wk_q;
          ld_wdata_o = '{inc: ent_inc_q,
                         load: sat_add(acc_q, cfg_i.recovery_penalty)};
        end
        err_d[wk_q]   = 1'b0;
        rec_d[wk_q]   = 1'b0;
        fin_valid     = 1'b1;
        fin_res.found = 1'b1;
        state_d       = ST_IDLE;
      end

      ST_HOLD: ;

      default: state_d = ST_IDLE;
    endcase

    if (state_q == ST_HOLD) begin
      if (out_free) begin
        load_out  = 1'b1;
        out_res_d = hold_res_q;
        state_d   = ST_IDLE;
      end
    end else if (fin_valid) begin
      if (out_free) begin
        load_out  = 1'b1;
        out_res_d = fin_res;
      end else begin
        hold_res_d = fin_res;
        state_d    = ST_HOLD;
      end
    end

    out_valid_d = load_out || (out_valid_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= 1'b0;
      ev_valid_q  <= 1'b0;
      err_q       <= '0;
      rec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      ev_valid_q  <= ev_valid_d;
      err_q       <= err_d;
      rec_q       <= rec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    rd_pass_q  <= rd_pass_d;
    ev_idx_q   <= ev_idx_d;
    ev_pass_q  <= ev_pass_d;
    now_q      <= now_d;
    wk_q       <= wk_d;
    have_q     <= have_d;
    stop_q     <= stop_d;
    probe_q    <= probe_d;
    pick_q     <= pick_d;
    acc_q      <= acc_d;
    ent_load_q <= ent_load_d;
    ent_inc_q  <= ent_inc_d;
    hold_res_q <= hold_res_d;
    out_res_q  <= out_res_d;
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_res_q.found;
  assign rsp_o.chosen     = out_res_q.chosen;
  assign rsp_o.probe      = out_res_q.probe;
  assign rsp_o.sticky_hit = out_res_q.sticky_hit;

endmodule

FILE: rtl/weighted_failover_worker_selector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weighted failover worker selector
// Least-load worker selection with sticky routes and failover probing.
// ---------------------------------------------------------------------------
// Requests arrive on req_i (valid/ready), one transaction per command:
// select, report success, report failure or load increment. Each request
// gives exactly one response transaction on rsp_o. The user must write settings
// over the APB port only while no request is in flight; the block does not
// enforce this. A load, a failure report, a plain success report and a select
// that takes its sticky route give their response straight from the idle
// state, which stays ready for the next request unless the output register
// is still full. A select that scans reads one table entry per cycle from
// the load and error-time memories, N being the workers in use: local
// workers in a first pass and the rest in a second. A success report on a
// recovering worker makes one pass over the loads.
// The response sits in an output register; when the receiver stalls, one
// more request is still taken and processed, and its response waits until
// the output register frees up. Reset clears the error and recovery flags
// and loads the register defaults; loads and increments stay undefined
// until a load command writes them.
module weighted_failover_worker_selector #(
  parameter int MAX_WORKERS = wfws_pkg::MAX_WORKERS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  wfws_req_if.sink                    req_i,
  wfws_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wfws_pkg::ADDR_W-1:0] paddr,
  input  logic [wfws_pkg::DATA_W-1:0] pwdata,
  output logic [wfws_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import wfws_pkg::*;

  localparam int IDX_W = $clog2(MAX_WORKERS);

  cfg_t              cfg;
  logic              ld_we;
  logic [IDX_W-1:0]  ld_waddr;
  load_ent_t         ld_wdata;
  logic [IDX_W-1:0]  ld_raddr;
  load_ent_t         ld_rdata;
  logic              tm_we;
  logic [IDX_W-1:0]  tm_waddr;
  logic [TIME_W-1:0] tm_wdata;
  logic [IDX_W-1:0]  tm_raddr;
  logic [TIME_W-1:0] tm_rdata;

  wfws_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wfws_ram #(
    .WIDTH ($bits(load_ent_t)),
    .DEPTH (MAX_WORKERS)
  ) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_waddr),
    .wdata_i (ld_wdata),
    .raddr_i (ld_raddr),
    .rdata_o (ld_rdata)
  );

  wfws_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_WORKERS)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (tm_we),
    .waddr_i (tm_waddr),
    .wdata_i (tm_wdata),
    .raddr_i (tm_raddr),
    .rdata_o (tm_rdata)
  );

  wfws_ctrl #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .ld_we_o    (ld_we),
    .ld_waddr_o (ld_waddr),
    .ld_wdata_o (ld_wdata),
    .ld_raddr_o (ld_raddr),
    .ld_rdata_i (ld_rdata),
    .tm_we_o    (tm_we),
    .tm_waddr_o (tm_waddr),
    .tm_wdata_o (tm_wdata),
    .tm_raddr_o (tm_raddr),
    .tm_rdata_i (tm_rdata)
  );

endmodule

FILE: rtl/wfws_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weighted failover worker selector checker
// Port-level assertions on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "weighted_failover_worker_selector_macros.svh"

module wfws_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     rsp_valid_i,
  input logic                     rsp_ready_i,
  input logic                     rsp_found_i,
  input logic [wfws_pkg::WK_W-1:0] rsp_chosen_i,
  input logic                     rsp_probe_i,
  input logic                     rsp_sticky_hit_i
);
  import wfws_pkg::*;

  `WFWS_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "response dropped while stalled")
  `WFWS_ASSERT_NXT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, $stable({rsp_found_i, rsp_chosen_i, rsp_probe_i, rsp_sticky_hit_i}), "response changed while stalled")
  `WFWS_ASSERT_IMP(a_none_clear, clk_i, rst_ni, rsp_valid_i && !rsp_found_i, rsp_chosen_i == '0 && !rsp_probe_i && !rsp_sticky_hit_i, "empty response carries a choice")
  `WFWS_ASSERT_IMP(a_kind_excl, clk_i, rst_ni, rsp_valid_i && (rsp_probe_i || rsp_sticky_hit_i), rsp_found_i && !(rsp_probe_i && rsp_sticky_hit_i), "probe and sticky hit overlap")

endmodule

bind weighted_failover_worker_selector wfws_checker u_wfws_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_found_i      (rsp_o.found),
  .rsp_chosen_i     (rsp_o.chosen),
  .rsp_probe_i      (rsp_o.probe),
  .rsp_sticky_hit_i (rsp_o.sticky_hit)
);
